@@ rtl/core/lrp_pkg.sv @@
// Shared types and constants for the LR shift-reduce parser.
// Holds the item structs, the code enums and the sequencer state type.
// No dependencies.
package lrp_pkg;

  localparam int STATE_W = 8;
  localparam logic [5:0] END_MARKER_RESET = 6'd63;

  typedef enum logic [1:0] {
    CMD_WRITE_ACTION = 2'd0,
    CMD_WRITE_GOTO   = 2'd1,
    CMD_PARSE        = 2'd2,
    CMD_START        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SHIFT  = 2'd1,
    KIND_REDUCE = 2'd2,
    KIND_ACCEPT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_SHIFT    = 3'd0,
    OUT_REDUCE   = 3'd1,
    OUT_ACCEPT   = 3'd2,
    OUT_NOACTION = 3'd3,
    OUT_STACKERR = 3'd4,
    OUT_IGNORED  = 3'd5
  } outcome_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  table_state;
    logic [5:0]  symbol;
    kind_t       entry_kind;
    logic [7:0]  target_state;
    logic [5:0]  rule_number;
    logic [4:0]  rule_left;
    logic [3:0]  rule_length;
  } in_item_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  new_top_state;
    logic [5:0]  reduced_rule;
    logic [4:0]  reduced_left;
    logic [6:0]  stack_depth;
    logic        last;
  } out_item_t;

  // One action table entry as stored in the action memory.
  typedef struct packed {
    logic [3:0]  rule_length;
    logic [4:0]  rule_left;
    logic [5:0]  rule_number;
    logic [7:0]  target_state;
    kind_t       kind;
  } act_entry_t;

  localparam int ACT_ENTRY_W = $bits(act_entry_t);

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_POP,
    ST_GOTO
  } fsm_t;

endpackage

@@ rtl/core/lr_table_driven_parser_top.sv @@
// LR shift-reduce parser, top level: configuration register, sequencer and
// registered result output. Depends on lrp_pkg, lrp_ctrl and lrp_ram.
// A shift, accept or error result passes the EVAL state and the output register after
// its item is accepted; each reduce of a chain adds stack read, goto read, write back.
// Table writes and start items are handled in the idle state. No new item is taken
// before the last is through the read-modify-write loop through the three memories.
// After reset the action and goto memories are swept to zero, one entry a cycle,
// 2**max(log2 action depth, log2 goto depth) entries (16384 at the defaults).
module lr_table_driven_parser_top #(
  parameter int STATE_COUNT       = 256,
  parameter int TERMINAL_COUNT    = 64,
  parameter int NONTERMINAL_COUNT = 32,
  parameter int STACK_DEPTH       = 64,
  parameter int MAX_REDUCE_CHAIN  = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  lrp_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output lrp_pkg::out_item_t rsp,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_wdata
);

  logic           [5:0] end_marker;
  logic                 out_free;
  lrp_pkg::emit_t       emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker <= lrp_pkg::END_MARKER_RESET;
    end else if (cfg_we) begin
      end_marker <= cfg_wdata;
    end
  end

  lrp_ctrl #(
    .STATE_COUNT      (STATE_COUNT),
    .TERMINAL_COUNT   (TERMINAL_COUNT),
    .NONTERMINAL_COUNT(NONTERMINAL_COUNT),
    .STACK_DEPTH      (STACK_DEPTH),
    .MAX_REDUCE_CHAIN (MAX_REDUCE_CHAIN)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .end_marker(end_marker),
    .out_free  (out_free),
    .emit      (emit)
  );

  // The output register frees up in the same cycle its item is taken.
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit.valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      rsp <= emit.item;
    end
  end

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> out_free)
    else $error("result produced while the output register was still full");

  a_reduce_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.outcome != lrp_pkg::OUT_REDUCE |->
      rsp.reduced_rule == '0 && rsp.reduced_left == '0)
    else $error("rule fields set on a result that is not a reduce");

  a_reduce_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.outcome == lrp_pkg::OUT_REDUCE |-> !rsp.last)
    else $error("reduce result marked as the last of its item");

  a_shift_depth: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.outcome == lrp_pkg::OUT_SHIFT |-> rsp.stack_depth >= 7'd2)
    else $error("shift result with a stack of fewer than two states");

endmodule

@@ rtl/core/lrp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while no read is issued. No dependencies.
module lrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/lrp_ctrl.sv @@
// Parser sequencer: action, goto and state stack memories with the FSM
// that loads tables, runs reduce chains and produces results.
// Depends on lrp_pkg and lrp_ram.
module lrp_ctrl #(
  parameter int STATE_COUNT       = 256,
  parameter int TERMINAL_COUNT    = 64,
  parameter int NONTERMINAL_COUNT = 32,
  parameter int STACK_DEPTH       = 64,
  parameter int MAX_REDUCE_CHAIN  = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  lrp_pkg::in_item_t req,
  input  logic [5:0]       end_marker,
  input  logic             out_free,
  output lrp_pkg::emit_t   emit
);

  // Only rows and columns that the 8-bit state and 6-bit codes can reach get storage.
  localparam int ROWS    = (STATE_COUNT < 256) ? STATE_COUNT : 256;
  localparam int RW      = $clog2(ROWS);
  localparam int TCOLS   = (TERMINAL_COUNT < 64) ? TERMINAL_COUNT : 64;
  localparam int TW      = $clog2(TCOLS);
  localparam int NCOLS   = (NONTERMINAL_COUNT < 64) ? NONTERMINAL_COUNT : 64;
  localparam int NW      = (NCOLS > 1) ? $clog2(NCOLS) : 1;
  localparam int ACT_AW  = RW + TW;
  localparam int GOTO_AW = RW + NW;
  localparam int CLR_AW  = (ACT_AW > GOTO_AW) ? ACT_AW : GOTO_AW;
  localparam int SAW     = $clog2(STACK_DEPTH);
  localparam int CW      = $clog2(STACK_DEPTH + 1);
  localparam int RCW     = $clog2(MAX_REDUCE_CHAIN + 1);
  localparam int SW      = lrp_pkg::STATE_W;
  localparam int ACT_ENTRY_W = lrp_pkg::ACT_ENTRY_W;

  lrp_pkg::fsm_t state, state_next;

  logic [CLR_AW-1:0] clr_cnt;
  logic [SW-1:0]     top;
  logic [CW-1:0]     count;
  logic              active;
  logic [RCW-1:0]    reductions;
  logic [5:0]        sym_q;
  logic [5:0]        rule_q;
  logic [4:0]        left_q;
  logic [CW-1:0]     pop_count_q;
  logic              pop_zero_q;
  logic              act_ok_q;
  logic              goto_ok_q;

  // Memory ports.
  logic                   act_we, act_re, act_rd_ok;
  logic [ACT_AW-1:0]      act_waddr, act_raddr;
  logic [ACT_ENTRY_W-1:0] act_wdata, act_rdata;
  logic                   goto_we, goto_re, goto_rd_ok;
  logic [GOTO_AW-1:0]     goto_waddr, goto_raddr;
  logic [SW-1:0]          goto_wdata, goto_rdata;
  logic                   stk_we, stk_re;
  logic [SAW-1:0]         stk_waddr, stk_raddr;
  logic [SW-1:0]          stk_wdata, stk_rdata;

  lrp_ram #(.WIDTH(ACT_ENTRY_W), .DEPTH(2 ** ACT_AW)) u_act_ram (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .re(act_re), .raddr(act_raddr), .rdata(act_rdata)
  );

  lrp_ram #(.WIDTH(SW), .DEPTH(2 ** GOTO_AW)) u_goto_ram (
    .clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
    .re(goto_re), .raddr(goto_raddr), .rdata(goto_rdata)
  );

  lrp_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Lookup decode of the action entry read for the current symbol.
  lrp_pkg::act_entry_t act_e;
  lrp_pkg::outcome_t   ev_out;
  logic                ev_reduce, ev_push, ev_kill;
  logic [CW-1:0]       pop_count;
  logic [SW-1:0]       exposed;
  logic [SW-1:0]       goto_state;
  logic [5:0]          left_ext;

  always_comb begin
    act_e     = act_ok_q ? lrp_pkg::act_entry_t'(act_rdata) : '0;
    ev_out    = lrp_pkg::OUT_NOACTION;
    ev_reduce = 1'b0;
    ev_push   = 1'b0;
    ev_kill   = 1'b1;
    pop_count = count - CW'(act_e.rule_length);
    if (!active) begin
      ev_out  = lrp_pkg::OUT_IGNORED;
      ev_kill = 1'b0;
    end else if (act_e.kind == lrp_pkg::KIND_SHIFT) begin
      if (32'(count) >= STACK_DEPTH) begin
        ev_out = lrp_pkg::OUT_STACKERR;
      end else begin
        ev_out  = lrp_pkg::OUT_SHIFT;
        ev_push = 1'b1;
        ev_kill = 1'b0;
      end
    end else if (act_e.kind == lrp_pkg::KIND_ACCEPT && sym_q == end_marker) begin
      ev_out = lrp_pkg::OUT_ACCEPT;
    end else if (act_e.kind != lrp_pkg::KIND_REDUCE) begin
      ev_out = lrp_pkg::OUT_NOACTION;
    end else if (32'(reductions) >= MAX_REDUCE_CHAIN ||
                 32'(act_e.rule_length) >= 32'(count)) begin
      ev_out = lrp_pkg::OUT_STACKERR;
    end else begin
      ev_out    = lrp_pkg::OUT_REDUCE;
      ev_reduce = 1'b1;
      ev_kill   = 1'b0;
    end
    // The bottom stack entry is always state zero and is never stored.
    exposed    = pop_zero_q ? '0 : stk_rdata;
    goto_state = goto_ok_q ? goto_rdata : '0;
    left_ext   = {1'b0, left_q};
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lrp_pkg::ST_CLEAR: begin
        if (&clr_cnt) begin
          state_next = lrp_pkg::ST_IDLE;
        end
      end
      lrp_pkg::ST_IDLE: begin
        if (req_valid && req.command == lrp_pkg::CMD_PARSE) begin
          state_next = lrp_pkg::ST_EVAL;
        end
      end
      lrp_pkg::ST_EVAL: begin
        if (ev_reduce) begin
          state_next = lrp_pkg::ST_POP;
        end else if (out_free) begin
          state_next = lrp_pkg::ST_IDLE;
        end
      end
      lrp_pkg::ST_POP: begin
        state_next = lrp_pkg::ST_GOTO;
      end
      lrp_pkg::ST_GOTO: begin
        if (out_free) begin
          state_next = lrp_pkg::ST_EVAL;
        end
      end
      default: begin
        state_next = lrp_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: memory ports, handshake and results.
  always_comb begin
    req_stall  = 1'b1;
    act_we     = 1'b0;
    act_waddr  = '0;
    act_wdata  = '0;
    act_re     = 1'b0;
    act_raddr  = '0;
    act_rd_ok  = 1'b0;
    goto_we    = 1'b0;
    goto_waddr = '0;
    goto_wdata = '0;
    goto_re    = 1'b0;
    goto_raddr = '0;
    goto_rd_ok = 1'b0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_re     = 1'b0;
    stk_raddr  = '0;
    emit       = '0;
    unique case (state)
      lrp_pkg::ST_CLEAR: begin
        act_we     = (clr_cnt >> ACT_AW) == '0;
        act_waddr  = clr_cnt[ACT_AW-1:0];
        goto_we    = (clr_cnt >> GOTO_AW) == '0;
        goto_waddr = clr_cnt[GOTO_AW-1:0];
      end
      lrp_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        act_waddr = {req.table_state[RW-1:0], req.symbol[TW-1:0]};
        act_wdata = ACT_ENTRY_W'({req.rule_length, req.rule_left, req.rule_number,
                                  req.target_state, req.entry_kind});
        goto_waddr = {req.table_state[RW-1:0], req.symbol[NW-1:0]};
        goto_wdata = req.target_state;
        act_raddr  = {top[RW-1:0], req.symbol[TW-1:0]};
        act_rd_ok  = 32'(top) < STATE_COUNT && 32'(req.symbol) < TERMINAL_COUNT;
        if (req_valid) begin
          unique case (req.command)
            lrp_pkg::CMD_WRITE_ACTION: begin
              act_we = 32'(req.table_state) < STATE_COUNT &&
                       32'(req.symbol) < TERMINAL_COUNT;
            end
            lrp_pkg::CMD_WRITE_GOTO: begin
              goto_we = 32'(req.table_state) < STATE_COUNT &&
                        32'(req.symbol) < NONTERMINAL_COUNT;
            end
            lrp_pkg::CMD_PARSE: begin
              act_re = 1'b1;
            end
            lrp_pkg::CMD_START: begin
              act_re = 1'b0;
            end
            default: begin
              act_re = 1'b0;
            end
          endcase
        end
      end
      lrp_pkg::ST_EVAL: begin
        stk_raddr = SAW'(pop_count - CW'(1));
        stk_waddr = SAW'(count);
        stk_wdata = act_e.target_state;
        if (ev_reduce) begin
          stk_re = 1'b1;
        end else if (out_free) begin
          stk_we                   = ev_push;
          emit.valid               = 1'b1;
          emit.item.outcome        = ev_out;
          emit.item.new_top_state  = ev_push ? act_e.target_state : top;
          emit.item.stack_depth    = ev_push ? 7'(count + CW'(1)) : 7'(count);
          emit.item.last           = 1'b1;
        end
      end
      lrp_pkg::ST_POP: begin
        goto_re    = 1'b1;
        goto_raddr = {exposed[RW-1:0], left_ext[NW-1:0]};
        goto_rd_ok = 32'(exposed) < STATE_COUNT && 32'(left_q) < NONTERMINAL_COUNT;
      end
      lrp_pkg::ST_GOTO: begin
        act_raddr = {goto_state[RW-1:0], sym_q[TW-1:0]};
        act_rd_ok = 32'(goto_state) < STATE_COUNT && 32'(sym_q) < TERMINAL_COUNT;
        stk_waddr = SAW'(pop_count_q);
        stk_wdata = goto_state;
        if (out_free) begin
          act_re                  = 1'b1;
          stk_we                  = 1'b1;
          emit.valid              = 1'b1;
          emit.item.outcome       = lrp_pkg::OUT_REDUCE;
          emit.item.new_top_state = goto_state;
          emit.item.reduced_rule  = rule_q;
          emit.item.reduced_left  = left_q;
          emit.item.stack_depth   = 7'(pop_count_q + CW'(1));
          emit.item.last          = 1'b0;
        end
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lrp_pkg::ST_CLEAR;
      clr_cnt    <= '0;
      top        <= '0;
      count      <= CW'(1);
      active     <= 1'b1;
      reductions <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        lrp_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + CLR_AW'(1);
        end
        lrp_pkg::ST_IDLE: begin
          if (req_valid && req.command == lrp_pkg::CMD_START) begin
            top    <= '0;
            count  <= CW'(1);
            active <= 1'b1;
          end
          if (req_valid && req.command == lrp_pkg::CMD_PARSE) begin
            reductions <= '0;
          end
        end
        lrp_pkg::ST_EVAL: begin
          if (!ev_reduce && out_free) begin
            if (ev_push) begin
              top   <= act_e.target_state;
              count <= count + CW'(1);
            end
            if (ev_kill) begin
              active <= 1'b0;
            end
          end
        end
        lrp_pkg::ST_POP: begin
          top <= top;
        end
        lrp_pkg::ST_GOTO: begin
          if (out_free) begin
            top        <= goto_state;
            count      <= pop_count_q + CW'(1);
            reductions <= reductions + RCW'(1);
          end
        end
        default: begin
          top <= top;
        end
      endcase
    end
  end

  // Item payload and lookup bookkeeping.
  always_ff @(posedge clk) begin
    if (state == lrp_pkg::ST_IDLE && req_valid && req.command == lrp_pkg::CMD_PARSE) begin
      sym_q <= req.symbol;
    end
    if (state == lrp_pkg::ST_EVAL && ev_reduce) begin
      rule_q      <= act_e.rule_number;
      left_q      <= act_e.rule_left;
      pop_count_q <= pop_count;
      pop_zero_q  <= pop_count == CW'(1);
    end
    if (act_re) begin
      act_ok_q <= act_rd_ok;
    end
    if (goto_re) begin
      goto_ok_q <= goto_rd_ok;
    end
  end

endmodule
